// ===== rtl/wsd_pkg.sv =====
`timescale 1ns / 1ps
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_RSV      = 3'd0,
    ERR_UNMASKED = 3'd1,
    ERR_OPCODE   = 3'd2,
    ERR_CTRL     = 3'd3,
    ERR_SHORT16  = 3'd4,
    ERR_TOPBIT   = 3'd5,
    ERR_SHORT64  = 3'd6,
    ERR_LONG     = 3'd7
  } err_t;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0]  LEN7_MAX      = 7'd125;
  localparam int          LEN16_MIN     = 126;
  localparam int          LEN16_MAX     = 65535;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    kind_t       kind;
    err_t        code;
    logic        fin;
    logic [3:0]  opcode;
    logic [31:0] len;
    logic [7:0]  data;
    logic [7:0]  key;
    logic        frame_end;
  } item_t;

  function automatic logic known_opcode(input logic [3:0] op);
    return op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
  endfunction

endpackage

// ===== rtl/wsd_front.sv =====
`timescale 1ns / 1ps
module wsd_front #(
  parameter int LENGTH_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           in_new,
  input  logic           q_full,
  input  logic           max_payload_we,
  input  logic [31:0]    max_payload_wdata,
  output logic           push,
  output wsd_pkg::item_t item
);
  import wsd_pkg::*;

  localparam int CW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  phase_t                 state, state_next, phase;
  logic                   frame_fin;
  logic [3:0]             frame_opcode;
  logic                   ext64;
  logic [2:0]             hdr_count;
  logic [LENGTH_BITS-1:0] length_accum;
  logic                   length_ovf;
  logic [31:0]            mask_key;
  logic [31:0]            payload_left;
  logic [1:0]             mask_index;
  logic [31:0]            max_payload;

  logic                   fire;
  logic [LENGTH_BITS-1:0] acc_shift;
  logic                   ovf_shift;
  logic [CW-1:0]          acc_ext;
  logic                   too_long_shift;
  logic [6:0]             lc;
  logic                   lc_short;
  logic                   fail;
  err_t                   fail_code;
  logic                   ext_last;
  logic                   hdr_done;
  logic [7:0]             key_byte;

  assign in_ready       = !q_full;
  assign fire           = in_valid && in_ready;
  assign phase          = in_new ? PH_FIRST : state;
  assign acc_shift      = {length_accum[LENGTH_BITS-9:0], in_byte};
  assign ovf_shift      = length_ovf || (length_accum[LENGTH_BITS-1 -: 8] != 8'd0);
  assign acc_ext        = CW'(acc_shift);
  assign too_long_shift = ovf_shift || (acc_ext > CW'(max_payload));
  assign lc             = in_byte[6:0];
  assign lc_short       = (lc <= LEN7_MAX);
  assign key_byte       = mask_key[{~mask_index, 3'b000} +: 8];

  // classify the current byte
  always_comb begin
    fail      = 1'b0;
    fail_code = ERR_RSV;
    ext_last  = 1'b0;
    hdr_done  = 1'b0;
    case (phase)
      PH_FIRST: begin
        if (in_byte[6:4] != 3'd0) begin
          fail = 1'b1;
          fail_code = ERR_RSV;
        end else if (!known_opcode(in_byte[3:0])) begin
          fail = 1'b1;
          fail_code = ERR_OPCODE;
        end else if (in_byte[3] && !in_byte[7]) begin
          fail = 1'b1;
          fail_code = ERR_CTRL;
        end
      end
      PH_SECOND: begin
        if (!in_byte[7]) begin
          fail = 1'b1;
          fail_code = ERR_UNMASKED;
        end else if (frame_opcode[3] && !lc_short) begin
          fail = 1'b1;
          fail_code = ERR_CTRL;
        end else if (lc_short && ({25'd0, lc} > max_payload)) begin
          fail = 1'b1;
          fail_code = ERR_LONG;
        end
      end
      PH_EXTLEN: begin
        ext_last = ext64 ? (hdr_count == 3'd7) : (hdr_count == 3'd1);
        if (ext64 && (hdr_count == 3'd0) && in_byte[7]) begin
          fail = 1'b1;
          fail_code = ERR_TOPBIT;
        end else if (ext_last) begin
          if (!ext64 && (acc_ext < CW'(LEN16_MIN))) begin
            fail = 1'b1;
            fail_code = ERR_SHORT16;
          end else if (ext64 && !ovf_shift && (acc_ext <= CW'(LEN16_MAX))) begin
            fail = 1'b1;
            fail_code = ERR_SHORT64;
          end else if (too_long_shift) begin
            fail = 1'b1;
            fail_code = ERR_LONG;
          end
        end
      end
      PH_KEY: begin
        hdr_done = (hdr_count[1:0] == 2'd3);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    if (fire) begin
      case (phase)
        PH_FIRST:   state_next = fail ? PH_HALT : PH_SECOND;
        PH_SECOND:  state_next = fail ? PH_HALT : (lc_short ? PH_KEY : PH_EXTLEN);
        PH_EXTLEN:  state_next = fail ? PH_HALT : (ext_last ? PH_KEY : PH_EXTLEN);
        PH_KEY: begin
          if (hdr_done) begin
            state_next = (length_accum == '0) ? PH_FIRST : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: state_next = (payload_left == 32'd1) ? PH_FIRST : PH_PAYLOAD;
        PH_HALT:    state_next = PH_HALT;
        default:    state_next = PH_FIRST;
      endcase
    end
  end

  always_comb begin
    push           = 1'b0;
    item.kind      = KIND_HEADER;
    item.code      = ERR_RSV;
    item.fin       = frame_fin;
    item.opcode    = frame_opcode;
    item.len       = 32'(length_accum);
    item.data      = 8'd0;
    item.key       = 8'd0;
    item.frame_end = 1'b0;
    if (fire) begin
      if (fail) begin
        push      = 1'b1;
        item.kind = KIND_ERROR;
        item.code = fail_code;
        item.len  = 32'd0;
        if (phase == PH_FIRST) begin
          item.fin    = in_byte[7];
          item.opcode = in_byte[3:0];
        end
      end else if (hdr_done) begin
        push           = 1'b1;
        item.frame_end = (length_accum == '0);
      end else if (phase == PH_PAYLOAD) begin
        push           = 1'b1;
        item.kind      = KIND_PAYLOAD;
        item.data      = in_byte;
        item.key       = key_byte;
        item.frame_end = (payload_left == 32'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= PH_FIRST;
      max_payload <= MAX_PAYLOAD_RESET;
      hdr_count   <= 3'd0;
      mask_index  <= 2'd0;
    end else begin
      state <= state_next;
      if (max_payload_we) begin
        max_payload <= max_payload_wdata;
      end
      if (fire) begin
        case (phase)
          PH_FIRST: begin
            frame_fin    <= in_byte[7];
            frame_opcode <= in_byte[3:0];
          end
          PH_SECOND: begin
            ext64        <= in_byte[0];
            length_accum <= lc_short ? LENGTH_BITS'(lc) : '0;
            length_ovf   <= 1'b0;
            hdr_count    <= 3'd0;
          end
          PH_EXTLEN: begin
            length_accum <= acc_shift;
            length_ovf   <= ovf_shift;
            hdr_count    <= ext_last ? 3'd0 : hdr_count + 3'd1;
          end
          PH_KEY: begin
            mask_key  <= {mask_key[23:0], in_byte};
            hdr_count <= hdr_done ? 3'd0 : hdr_count + 3'd1;
            if (hdr_done) begin
              payload_left <= 32'(length_accum);
              mask_index   <= 2'd0;
            end
          end
          PH_PAYLOAD: begin
            mask_index   <= mask_index + 2'd1;
            payload_left <= payload_left - 32'd1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (state == PH_HALT && !in_new) |-> !push)
    else $error("item pushed while halted on an error");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (push && item.kind == KIND_ERROR) |=> (state == PH_HALT))
    else $error("error item did not latch the halt state");

endmodule

// ===== rtl/wsd_queue.sv =====
`timescale 1ns / 1ps
module wsd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wsd_pkg::item_t wr_item,
  input  logic           pop,
  output wsd_pkg::item_t rd_item,
  output logic           full,
  output logic           empty
);
  import wsd_pkg::*;

  item_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full queue");

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop && count == (QPTR_W+1)'(QDEPTH - 1)) |=> full)
    else $error("queue count lost an item");

endmodule

// ===== rtl/wsd_back.sv =====
`timescale 1ns / 1ps
module wsd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  wsd_pkg::item_t q_item,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [47:0]    m_tdata,
  output logic [1:0]     m_tuser,
  output logic           m_tlast
);
  import wsd_pkg::*;

  logic        load;
  kind_t       out_kind;
  err_t        out_code;
  logic        out_fin;
  logic [3:0]  out_opcode;
  logic [31:0] out_len;
  logic [7:0]  out_byte;
  logic        out_end;

  assign load  = !q_empty && (!m_tvalid || m_tready);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // unmask on the way out
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind   <= q_item.kind;
      out_code   <= q_item.code;
      out_fin    <= q_item.fin;
      out_opcode <= q_item.opcode;
      out_len    <= q_item.len;
      out_byte   <= q_item.data ^ q_item.key;
      out_end    <= q_item.frame_end;
    end
  end

  assign m_tdata = {out_byte, out_len, out_opcode, out_fin, out_code};
  assign m_tuser = out_kind;
  assign m_tlast = out_end;

endmodule

// ===== rtl/websocket_client_frame_deframer.sv =====
`timescale 1ns / 1ps
// client-to-server websocket deframer, one stream byte per item
// s_* channel: tdata[7:0] raw byte, tuser marks the first byte of a new stream
//   (drops any partial frame and a latched error)
// m_* channel: one result per header, per payload byte and per protocol error;
//   tuser carries the result kind, tlast marks the last result of a frame
// max_payload_we / max_payload_wdata write the largest accepted payload length
// the result of an accepted byte reaches m_* through the queue and the output register
// throughput is one byte per clock while the queue is not full; the parser decides each byte combinationally
// and a four-entry queue plus the output register sit between parser and output
// when m_tready is low the queue fills and s_tready drops once it is full
// after an error no result appears until a byte with tuser set
// reset clears the parser, the queue and the output, and max_payload to 1048576
module websocket_client_frame_deframer #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tuser,   // new_stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // error_code, fin, opcode, payload_length, out_byte
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast,   // frame_end
  input  logic        max_payload_we,
  input  logic [31:0] max_payload_wdata
);
  import wsd_pkg::*;

  logic  push;
  item_t wr_item;
  item_t rd_item;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  wsd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (s_tvalid),
    .in_ready          (s_tready),
    .in_byte           (s_tdata),
    .in_new            (s_tuser),
    .q_full            (q_full),
    .max_payload_we    (max_payload_we),
    .max_payload_wdata (max_payload_wdata),
    .push              (push),
    .item              (wr_item)
  );

  wsd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (q_pop),
    .rd_item (rd_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  wsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_item   (rd_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
